### rtl/vaf_pkg.sv
// ----------------------------------------------------------------------------
// vaf_pkg: shared types and constants of the full-circle vector angle core
// Binary-angle constants, the arctangent table of the rotation cells, the
// scale factors of the angle outputs and the types that travel down the row.
// ----------------------------------------------------------------------------
package vaf_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int ANGLE_STAGES_DEF = 16;

   // rotation datapath: magnitudes sit left-aligned with two spare top bits
   localparam int CORDIC_WIDTH = 64;
   localparam int Z_WIDTH      = 32;
   localparam int REF_WIDTH    = 31;
   localparam int TABLE_LEN    = 32;

   // binary angle: one full turn is 2^32
   localparam logic [REF_WIDTH-1:0] BAM_90  = 31'h4000_0000;
   localparam logic [31:0]          BAM_180 = 32'h8000_0000;

   // output scaling: pi * 2^30 for radians, 360 * 256 for degrees
   localparam logic [31:0] PI_Q30    = 32'hC90F_DAA2;
   localparam logic [16:0] DEG_SCALE = 17'd92160;

   localparam int RAD_WIDTH = 16;
   localparam int DEG_WIDTH = 17;

   // atan(2^-i) in binary-angle units
   localparam logic [31:0] ATAN_BAM [TABLE_LEN] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
      32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
   };

   // how the reference angle of an item is found
   typedef enum logic [1:0] {
      KIND_ROTATE = 2'd0,
      KIND_ON_X   = 2'd1,
      KIND_ON_Y   = 2'd2,
      KIND_NULL   = 2'd3
   } ref_kind_type;

   typedef struct packed {
      logic signed [CORDIC_WIDTH-1:0] xs;
      logic signed [CORDIC_WIDTH-1:0] ys;
      logic signed [Z_WIDTH-1:0]      z;
      logic                           x_neg;
      logic                           y_neg;
      ref_kind_type                   kind;
   } cordic_type;

endpackage

### rtl/vaf_if.sv
// ----------------------------------------------------------------------------
// vaf_if: item channels of the full-circle vector angle core
// Valid/ready channels for the input vector and for the angle result.
// ----------------------------------------------------------------------------
interface vaf_req_if #(
   parameter int COORD_WIDTH = vaf_pkg::COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vaf_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [vaf_pkg::RAD_WIDTH-1:0]    angle_radians;
   logic [vaf_pkg::DEG_WIDTH-1:0]    angle_degrees;
   logic                             zero_vector;

   modport source (output valid, output angle_radians, output angle_degrees,
                   output zero_vector, input ready);
   modport sink   (input valid, input angle_radians, input angle_degrees,
                   input zero_vector, output ready);
endinterface

### rtl/vaf_prep.sv
// ----------------------------------------------------------------------------
// vaf_prep: input stage of the vector angle core
// Takes magnitudes and signs of the vector, sorts out the axis cases and
// loads the left-aligned magnitudes for the rotation cells.
// ----------------------------------------------------------------------------
module vaf_prep #(
   parameter int COORD_WIDTH = vaf_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [COORD_WIDTH-1:0] x_coord,
   input  logic signed [COORD_WIDTH-1:0] y_coord,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output vaf_pkg::cordic_type           dn_data
);

   localparam int GUARD_BITS = vaf_pkg::CORDIC_WIDTH - 2 - COORD_WIDTH;

   logic                      valid_ff, valid_in;
   vaf_pkg::cordic_type       data_ff, data_in;
   logic [COORD_WIDTH-1:0]    x_bits, y_bits, ax, ay;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      x_bits = x_coord;
      y_bits = y_coord;
      // the most negative value keeps its exact magnitude as unsigned
      ax = x_bits[COORD_WIDTH-1] ? (~x_bits + 1'b1) : x_bits;
      ay = y_bits[COORD_WIDTH-1] ? (~y_bits + 1'b1) : y_bits;
      data_in.xs    = {2'b00, ax, {GUARD_BITS{1'b0}}};
      data_in.ys    = {2'b00, ay, {GUARD_BITS{1'b0}}};
      data_in.z     = '0;
      data_in.x_neg = x_bits[COORD_WIDTH-1];
      data_in.y_neg = y_bits[COORD_WIDTH-1];
      if (ax == '0 && ay == '0) begin
         data_in.kind = vaf_pkg::KIND_NULL;
      end else if (ay == '0) begin
         data_in.kind = vaf_pkg::KIND_ON_X;
      end else if (ax == '0) begin
         data_in.kind = vaf_pkg::KIND_ON_Y;
      end else begin
         data_in.kind = vaf_pkg::KIND_ROTATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

### rtl/vaf_cell.sv
// ----------------------------------------------------------------------------
// vaf_cell: one rotation cell of the vector angle core
// Rotates the vector toward the x axis by atan(2^-STAGE_IDX) and adds the
// rotation to the angle, then hands the item to the next cell.
// ----------------------------------------------------------------------------
module vaf_cell #(
   parameter int STAGE_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  vaf_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output vaf_pkg::cordic_type dn_data
);

   localparam logic signed [vaf_pkg::Z_WIDTH-1:0] STEP_ANGLE =
      vaf_pkg::ATAN_BAM[STAGE_IDX];

   logic                                     valid_ff, valid_in;
   vaf_pkg::cordic_type                      data_ff, data_in;
   logic signed [vaf_pkg::CORDIC_WIDTH-1:0]  dx, dy;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      dx      = up_data.ys >>> STAGE_IDX;
      dy      = up_data.xs >>> STAGE_IDX;
      data_in = up_data;
      // rotate clockwise while y is still above the axis, else back
      if (!up_data.ys[vaf_pkg::CORDIC_WIDTH-1]) begin
         data_in.xs = up_data.xs + dx;
         data_in.ys = up_data.ys - dy;
         data_in.z  = up_data.z + STEP_ANGLE;
      end else begin
         data_in.xs = up_data.xs - dx;
         data_in.ys = up_data.ys + dy;
         data_in.z  = up_data.z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // x only grows through the row and must never wrap into the sign bit
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !data_ff.xs[vaf_pkg::CORDIC_WIDTH-1])
      else $error("vaf_cell: x magnitude overflowed");

endmodule

### rtl/vaf_post.sv
// ----------------------------------------------------------------------------
// vaf_post: angle finish of the vector angle core
// Clamps the reference angle, places it in its quadrant as a binary angle,
// then scales it to radians and degrees in the output register.
// ----------------------------------------------------------------------------
module vaf_post (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  vaf_pkg::cordic_type               up_data,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [vaf_pkg::RAD_WIDTH-1:0]     angle_radians,
   output logic [vaf_pkg::DEG_WIDTH-1:0]     angle_degrees,
   output logic                              zero_vector
);

   localparam logic signed [vaf_pkg::Z_WIDTH-1:0] Z_90 =
      {1'b0, vaf_pkg::BAM_90};

   // quadrant stage
   logic                              a_valid_ff, a_valid_in, a_ready;
   logic [31:0]                       bam_ff, bam_in;
   logic                              a_zero_ff;
   logic [vaf_pkg::REF_WIDTH-1:0]     ref_angle;
   logic [31:0]                       ref_ext;

   // scale stage
   logic                              b_valid_ff, b_valid_in, b_ready;
   logic [vaf_pkg::RAD_WIDTH-1:0]     rad_ff;
   logic [vaf_pkg::DEG_WIDTH-1:0]     deg_ff;
   logic                              zero_ff;
   logic [63:0]                       rad_prod;
   logic [48:0]                       deg_prod;

   assign b_ready    = !b_valid_ff || dn_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign up_ready   = a_ready;
   assign a_valid_in = a_ready ? up_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;

   always_comb begin
      case (up_data.kind)
         vaf_pkg::KIND_NULL: ref_angle = '0;
         vaf_pkg::KIND_ON_X: ref_angle = '0;
         vaf_pkg::KIND_ON_Y: ref_angle = vaf_pkg::BAM_90;
         default: begin
            if (up_data.z[vaf_pkg::Z_WIDTH-1]) begin
               ref_angle = '0;
            end else if (up_data.z > Z_90) begin
               ref_angle = vaf_pkg::BAM_90;
            end else begin
               ref_angle = up_data.z[vaf_pkg::REF_WIDTH-1:0];
            end
         end
      endcase
      ref_ext = {1'b0, ref_angle};
      case ({up_data.x_neg, up_data.y_neg})
         2'b00:   bam_in = ref_ext;
         2'b10:   bam_in = vaf_pkg::BAM_180 - ref_ext;
         2'b11:   bam_in = vaf_pkg::BAM_180 + ref_ext;
         default: bam_in = 32'd0 - ref_ext;
      endcase
      // the null vector leaves a zero angle behind for the scale stage
      if (up_data.kind == vaf_pkg::KIND_NULL) begin
         bam_in = '0;
      end
   end

   assign rad_prod = bam_ff * vaf_pkg::PI_Q30;
   assign deg_prod = bam_ff * vaf_pkg::DEG_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && a_ready) begin
         bam_ff    <= bam_in;
         a_zero_ff <= (up_data.kind == vaf_pkg::KIND_NULL);
      end
      if (a_valid_ff && b_ready) begin
         rad_ff  <= rad_prod[63:48];
         deg_ff  <= deg_prod[48:32];
         zero_ff <= a_zero_ff;
      end
   end

   assign dn_valid      = b_valid_ff;
   assign angle_radians = rad_ff;
   assign angle_degrees = deg_ff;
   assign zero_vector   = zero_ff;

   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && zero_ff) |-> (rad_ff == '0 && deg_ff == '0))
      else $error("vaf_post: null vector with a nonzero angle");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (rad_ff <= 16'd51471))
      else $error("vaf_post: radians at or above a full turn");

   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (deg_ff <= 17'd92159))
      else $error("vaf_post: degrees at or above a full turn");

   assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_ready) |=> (a_valid_ff && $stable(bam_ff)))
      else $error("vaf_post: quadrant stage lost a stalled item");

endmodule

### rtl/vector_angle_full_circle_core.sv
// ----------------------------------------------------------------------------
// vector_angle_full_circle_core: full-circle angle of a signed 2D vector
// Returns the angle of (x, y) from the positive x axis in [0, 2pi) as
// radians (13 fraction bits) and degrees (8 fraction bits).
// ----------------------------------------------------------------------------
// The core accepts one vector every clock cycle while its output is not held
// back, and returns one result per vector, in order. The path is one input
// stage, one rotation cell per angle stage in a row, one quadrant stage and
// one scaling stage that is the output register. Each stage stalls only
// when the one after it is full, so results waiting on the output do not
// stop new vectors from entering until the row fills. The zero vector sets
// zero_vector and reports angle 0; vectors on the axes give exactly 0, 90,
// 180 or 270 degrees.
// ----------------------------------------------------------------------------
module vector_angle_full_circle_core #(
   parameter int COORD_WIDTH  = vaf_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_STAGES = vaf_pkg::ANGLE_STAGES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   vaf_req_if.sink      req_ch,
   vaf_rsp_if.source    rsp_ch
);

   logic                chain_valid [ANGLE_STAGES+1];
   logic                chain_ready [ANGLE_STAGES+1];
   vaf_pkg::cordic_type chain_data  [ANGLE_STAGES+1];

   vaf_prep #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .x_coord  (req_ch.x_coord),
      .y_coord  (req_ch.y_coord),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
      vaf_cell #(
         .STAGE_IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   vaf_post u_post (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (chain_valid[ANGLE_STAGES]),
      .up_ready      (chain_ready[ANGLE_STAGES]),
      .up_data       (chain_data[ANGLE_STAGES]),
      .dn_valid      (rsp_ch.valid),
      .dn_ready      (rsp_ch.ready),
      .angle_radians (rsp_ch.angle_radians),
      .angle_degrees (rsp_ch.angle_degrees),
      .zero_vector   (rsp_ch.zero_vector)
   );

endmodule
